>>> rtl/timed_event_replay_queue_assert.svh
// Assertion macros for the timed event replay queue.
// Expects clk_i and rst_ni in the scope of the module that uses them.
`ifndef TIMED_EVENT_REPLAY_QUEUE_ASSERT_SVH
`define TIMED_EVENT_REPLAY_QUEUE_ASSERT_SVH

// Condition must hold at every rising clock edge outside reset.
`define TERQ_ASSERT_ALWAYS(lbl, cond) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (cond)) \
    else $error("assertion failed");

// Antecedent implies consequent in the same cycle.
`define TERQ_ASSERT_IMPL(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("assertion failed");

`endif

>>> rtl/terq_pkg.sv
// Types and codes for the timed event replay queue.
// No dependencies.
`default_nettype none
package terq_pkg;

  localparam logic OP_INSERT = 1'b0;
  localparam logic OP_REWIND = 1'b1;

  localparam logic [1:0] KIND_ACTION  = 2'd0;
  localparam logic [1:0] KIND_ADVANCE = 2'd1;
  localparam logic [1:0] KIND_RESET   = 2'd2;
  localparam logic [1:0] KIND_DONE    = 2'd3;

  localparam logic [1:0] ST_OK             = 2'd0;
  localparam logic [1:0] ST_BAD_EVENT_TIME = 2'd1;
  localparam logic [1:0] ST_FULL           = 2'd2;
  localparam logic [1:0] ST_BAD_REWIND     = 2'd3;

  localparam int TIME_W = 31;
  localparam int ACT_W  = 32;

  typedef struct packed {
    logic               operation;
    logic signed [31:0] time_value;
    logic [31:0]        action;
  } cmd_t;

  typedef struct packed {
    logic [1:0]  kind;
    logic [31:0] action_out;
    logic [30:0] delta;
    logic [1:0]  status;
    logic        last;
  } res_t;

endpackage
`default_nettype wire

>>> rtl/timed_event_replay_queue.sv
// Timed event replay queue: sorted event memory, insert and replay sequencer.
// Depends on terq_pkg and timed_event_replay_queue_assert.svh.
//
//   channel   | direction | handshake
//   command   | in        | start, busy, cmd_i
//   result    | out       | res_valid_o strobe, res_o
//   config    | in        | cfg_we_i, cfg_wdata_i
//
// Insert: one memory read and one compare/write per stored entry shifted up,
// working from the top of the store down.
// Rewind: walks the store from the cursor, giving a result per replayed entry and per advance.
// Each result strobes for one cycle; the receiver cannot stall.
// After reset the store is empty and resets on rewind are enabled.
`default_nettype none
module timed_event_replay_queue #(
  parameter int EVENT_DEPTH = 16
) (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire logic          start,
  output logic               busy,
  input  wire terq_pkg::cmd_t cmd_i,
  input  wire logic          cfg_we_i,
  input  wire logic          cfg_wdata_i,
  output logic               res_valid_o,
  output terq_pkg::res_t     res_o
);

  localparam int CW = $clog2(EVENT_DEPTH + 1);
  localparam int IW = (EVENT_DEPTH > 1) ? $clog2(EVENT_DEPTH) : 1;
  localparam int MW = terq_pkg::TIME_W + terq_pkg::ACT_W;
  localparam logic [CW-1:0] DEPTH_C = CW'(EVENT_DEPTH);

  localparam logic [2:0] S_IDLE   = 3'd0;
  localparam logic [2:0] S_INS_RD = 3'd1;
  localparam logic [2:0] S_INS_WR = 3'd2;
  localparam logic [2:0] S_RP_RD  = 3'd3;
  localparam logic [2:0] S_RP_CHK = 3'd4;
  localparam logic [2:0] S_RP_ACT = 3'd5;
  localparam logic [2:0] S_FIN    = 3'd6;
  localparam logic [2:0] S_DONE   = 3'd7;

  logic [2:0]               state_q, state_d;
  logic [CW-1:0]            count_q, count_d;
  logic [CW-1:0]            cursor_q, cursor_d;
  logic [CW-1:0]            hole_q, hole_d;
  logic [terq_pkg::TIME_W-1:0] now_q, now_d;
  logic [terq_pkg::TIME_W-1:0] tgt_q, tgt_d;
  logic [terq_pkg::ACT_W-1:0]  act_q, act_d;
  logic [1:0]               status_q, status_d;
  logic                     rst_en_q;
  logic                     res_valid_q, res_valid_d;
  terq_pkg::res_t           res_q, res_d;

  // event memory: {time, action}
  logic [MW-1:0]  mem_q [EVENT_DEPTH];
  logic [MW-1:0]  rdata_q;
  logic           mem_we, mem_re;
  logic [IW-1:0]  waddr, raddr;
  logic [MW-1:0]  wdata;
  logic [terq_pkg::TIME_W-1:0] rd_time;
  logic [terq_pkg::ACT_W-1:0]  rd_act;

  assign rd_time = rdata_q[MW-1 -: terq_pkg::TIME_W];
  assign rd_act  = rdata_q[terq_pkg::ACT_W-1:0];
  assign busy        = (state_q != S_IDLE);
  assign res_valid_o = res_valid_q;
  assign res_o       = res_q;

  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      mem_q[waddr] <= wdata;
    end
    if (mem_re) begin
      rdata_q <= mem_q[raddr];
    end
  end

  // sequencer
  always_comb begin
    logic [CW-1:0] hm1;
    hm1         = hole_q - CW'(1);
    state_d     = state_q;
    count_d     = count_q;
    cursor_d    = cursor_q;
    hole_d      = hole_q;
    now_d       = now_q;
    tgt_d       = tgt_q;
    act_d       = act_q;
    status_d    = status_q;
    res_valid_d = 1'b0;
    res_d       = '0;
    mem_we      = 1'b0;
    mem_re      = 1'b0;
    waddr       = hole_q[IW-1:0];
    raddr       = hm1[IW-1:0];
    wdata       = {tgt_q, act_q};

    unique case (state_q)
      S_IDLE: begin
        if (start) begin
          tgt_d    = cmd_i.time_value[30:0];
          act_d    = cmd_i.action;
          status_d = terq_pkg::ST_OK;
          state_d  = S_DONE;
          if (cmd_i.operation == terq_pkg::OP_INSERT) begin
            if (cmd_i.time_value[31] || cmd_i.time_value[30:0] < now_q) begin
              status_d = terq_pkg::ST_BAD_EVENT_TIME;
            end else if (count_q >= DEPTH_C) begin
              status_d = terq_pkg::ST_FULL;
            end else begin
              hole_d  = count_q;
              state_d = S_INS_RD;
            end
          end else if (cmd_i.time_value[31]) begin
            status_d = terq_pkg::ST_BAD_REWIND;
          end else if (cmd_i.time_value[30:0] < now_q) begin
            if (!rst_en_q) begin
              status_d = terq_pkg::ST_BAD_EVENT_TIME;
            end else begin
              res_valid_d = 1'b1;
              res_d.kind  = terq_pkg::KIND_RESET;
              now_d       = '0;
              cursor_d    = '0;
              state_d     = S_RP_RD;
            end
          end else if (cmd_i.time_value[30:0] != now_q) begin
            state_d = S_RP_RD;
          end
        end
      end
      // insert: move the hole down past later events
      S_INS_RD: begin
        if (hole_q == '0) begin
          mem_we  = 1'b1;
          count_d = count_q + CW'(1);
          state_d = S_DONE;
        end else begin
          mem_re  = 1'b1;
          state_d = S_INS_WR;
        end
      end
      S_INS_WR: begin
        mem_we = 1'b1;
        if (rd_time > tgt_q) begin
          wdata   = rdata_q;
          hole_d  = hm1;
          state_d = S_INS_RD;
        end else begin
          count_d = count_q + CW'(1);
          state_d = S_DONE;
        end
      end
      // replay walk from the cursor
      S_RP_RD: begin
        raddr = cursor_q[IW-1:0];
        if (cursor_q < count_q) begin
          mem_re  = 1'b1;
          state_d = S_RP_CHK;
        end else begin
          state_d = S_FIN;
        end
      end
      S_RP_CHK: begin
        if (rd_time < tgt_q) begin
          if (rd_time > now_q) begin
            res_valid_d = 1'b1;
            res_d.kind  = terq_pkg::KIND_ADVANCE;
            res_d.delta = rd_time - now_q;
            now_d       = rd_time;
            state_d     = S_RP_ACT;
          end else begin
            res_valid_d      = 1'b1;
            res_d.kind       = terq_pkg::KIND_ACTION;
            res_d.action_out = rd_act;
            cursor_d         = cursor_q + CW'(1);
            state_d          = S_RP_RD;
          end
        end else begin
          state_d = S_FIN;
        end
      end
      S_RP_ACT: begin
        res_valid_d      = 1'b1;
        res_d.kind       = terq_pkg::KIND_ACTION;
        res_d.action_out = rd_act;
        cursor_d         = cursor_q + CW'(1);
        state_d          = S_RP_RD;
      end
      S_FIN: begin
        if (now_q < tgt_q) begin
          res_valid_d = 1'b1;
          res_d.kind  = terq_pkg::KIND_ADVANCE;
          res_d.delta = tgt_q - now_q;
          now_d       = tgt_q;
        end
        state_d = S_DONE;
      end
      S_DONE: begin
        res_valid_d  = 1'b1;
        res_d.kind   = terq_pkg::KIND_DONE;
        res_d.status = status_q;
        res_d.last   = 1'b1;
        state_d      = S_IDLE;
      end
      default: state_d = S_IDLE;
    endcase
  end

  // control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      count_q     <= '0;
      cursor_q    <= '0;
      now_q       <= '0;
      rst_en_q    <= 1'b1;
      res_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      count_q     <= count_d;
      cursor_q    <= cursor_d;
      now_q       <= now_d;
      res_valid_q <= res_valid_d;
      if (cfg_we_i) begin
        rst_en_q <= cfg_wdata_i;
      end
    end
  end

  // transaction payload registers
  always_ff @(posedge clk_i) begin
    hole_q   <= hole_d;
    tgt_q    <= tgt_d;
    act_q    <= act_d;
    status_q <= status_d;
    res_q    <= res_d;
  end

`include "timed_event_replay_queue_assert.svh"
  `TERQ_ASSERT_ALWAYS(a_count_bound, count_q <= DEPTH_C)
  `TERQ_ASSERT_ALWAYS(a_cursor_bound, cursor_q <= count_q)
  `TERQ_ASSERT_IMPL(a_last_is_done, res_valid_o && res_o.last, res_o.kind == terq_pkg::KIND_DONE)
  `TERQ_ASSERT_IMPL(a_done_frees, res_valid_o && res_o.last, !busy)

endmodule
`default_nettype wire
